/* rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared sizes, opcodes and types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int IDX_W  = $clog2(CELL_COUNT);
    localparam int CNT_W  = $clog2(CELL_COUNT + 1);
    localparam int CELL_W = 16;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0]        NEWLINE_CODE = 8'd10;
    localparam logic [7:0]        ATTR_RESET   = 8'h0F;
    localparam logic [CELL_W-1:0] BLANK_RESET  = 16'h0F00;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_ram_req;

endpackage

/* rtl/tcw_ram.sv */
// ----------------------------------------------------------------------------
// tcw_ram
// Screen store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_ram (
    input  logic                      i_clk,
    input  tcw_pkg::t_ram_req         i_req,
    output logic [tcw_pkg::CELL_W-1:0] o_rdata
);

    logic [tcw_pkg::CELL_W-1:0] r_mem [tcw_pkg::CELL_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.raddr];
        end
    end

endmodule

/* rtl/tcw_engine.sv */
// ----------------------------------------------------------------------------
// tcw_engine
// Command sequencer: cursor, screen store sweeps and the result register.
// ----------------------------------------------------------------------------
module tcw_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_opcode,
    input  logic [7:0]                 i_char_code,
    input  logic [10:0]                i_cell_index,
    input  logic [7:0]                 i_attr,
    output tcw_pkg::t_ram_req          o_ram_req,
    input  logic [tcw_pkg::CELL_W-1:0] i_ram_rdata,
    output logic                       o_valid,
    input  logic                       i_out_ready,
    output logic [31:0]                o_data
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_SCROLL = 5'b00100,
        S_BLANK  = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state                      r_state, n_state;
    logic [tcw_pkg::ROW_W-1:0]   r_row, n_row;
    logic [tcw_pkg::COL_W-1:0]   r_col, n_col;
    logic [tcw_pkg::CNT_W-1:0]   r_ptr, n_ptr;
    logic                        r_rvalid, n_rvalid;
    logic                        r_init, n_init;
    logic [tcw_pkg::CELL_W-1:0]  r_blank, n_blank;
    logic [tcw_pkg::CELL_W-1:0]  r_value, n_value;
    logic                        r_scr, n_scr;
    logic                        r_out_valid, n_out_valid;
    logic [31:0]                 r_out_data, n_out_data;

    logic                        accept;
    logic                        newline;
    logic                        wrap;
    logic                        scroll;
    logic [tcw_pkg::COL_W:0]     col_inc;
    logic [tcw_pkg::ROW_W:0]     row_inc;
    logic                        out_free;
    logic                        src_left;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign src_left = (r_ptr < tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT));

    assign newline = (i_char_code == tcw_pkg::NEWLINE_CODE);
    assign col_inc = {1'b0, r_col} + 1'b1;
    assign row_inc = {1'b0, r_row} + 1'b1;
    assign wrap    = newline || (col_inc == (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS));
    assign scroll  = wrap && (row_inc == (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS));

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_ptr       = r_ptr;
        n_rvalid    = 1'b0;
        n_init      = r_init;
        n_blank     = r_blank;
        n_value     = r_value;
        n_scr       = r_scr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        o_ram_req   = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_value = '0;
                    n_scr   = 1'b0;
                    case (i_opcode)
                        tcw_pkg::OP_PUT: begin
                            // write the glyph at the cursor (a newline writes nothing), then move on
                            o_ram_req.we    = !newline;
                            o_ram_req.waddr = tcw_pkg::IDX_W'(r_row * tcw_pkg::COLUMNS
                                                              + r_col);
                            o_ram_req.wdata = {i_attr, i_char_code};
                            n_col = wrap ? '0 : col_inc[tcw_pkg::COL_W-1:0];
                            if (scroll) begin
                                n_row   = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
                                n_scr   = 1'b1;
                                n_ptr   = tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
                                n_blank = {i_attr, 8'h00};
                                n_state = S_SCROLL;
                            end else begin
                                if (wrap) begin
                                    n_row = row_inc[tcw_pkg::ROW_W-1:0];
                                end
                                n_state = S_RESULT;
                            end
                        end
                        tcw_pkg::OP_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_ptr   = '0;
                            n_blank = {i_attr, 8'h00};
                            n_state = S_BLANK;
                        end
                        tcw_pkg::OP_READ: begin
                            if (i_cell_index < 11'(tcw_pkg::CELL_COUNT)) begin
                                o_ram_req.re    = 1'b1;
                                o_ram_req.raddr = tcw_pkg::IDX_W'(i_cell_index);
                                n_state         = S_READ;
                            end else begin
                                n_state = S_RESULT;
                            end
                        end
                        default: begin
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_value = i_ram_rdata;
                n_state = S_RESULT;
            end
            S_SCROLL: begin
                // read one row ahead, write back the cell fetched last cycle
                o_ram_req.re    = src_left;
                o_ram_req.raddr = r_ptr[tcw_pkg::IDX_W-1:0];
                o_ram_req.we    = r_rvalid;
                o_ram_req.waddr = tcw_pkg::IDX_W'(r_ptr - tcw_pkg::CNT_W'(tcw_pkg::COLUMNS + 1));
                o_ram_req.wdata = i_ram_rdata;
                n_rvalid        = src_left;
                if (src_left) begin
                    n_ptr = r_ptr + 1'b1;
                end else begin
                    n_ptr   = tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS);
                    n_state = S_BLANK;
                end
            end
            S_BLANK: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_ptr[tcw_pkg::IDX_W-1:0];
                o_ram_req.wdata = r_blank;
                n_ptr           = r_ptr + 1'b1;
                if (r_ptr == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - 1)) begin
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_RESULT;
                end
            end
            S_RESULT: begin
                // hold until the output register is free
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {3'b000, r_scr, 7'(r_col), 5'(r_row), r_value};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BLANK;
            r_row       <= '0;
            r_col       <= '0;
            r_ptr       <= '0;
            r_rvalid    <= 1'b0;
            r_init      <= 1'b1;
            r_blank     <= tcw_pkg::BLANK_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_ptr       <= n_ptr;
            r_rvalid    <= n_rvalid;
            r_init      <= n_init;
            r_blank     <= n_blank;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value    <= n_value;
        r_scr      <= n_scr;
        r_out_data <= n_out_data;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

/* rtl/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: screen store of attribute and character cells, cursor.
// ----------------------------------------------------------------------------
// After reset the block blanks the whole screen store (80 x 25 cells, one cell
// per cycle) before it accepts its first transaction; attribute writes are
// taken throughout. A put writes its cell (a newline none) and a read fetches
// its cell from the store; each then posts its result. The scroll and the clear
// sweep the screen store (one read port, one write port) one cell per cycle;
// the scroll copies each row up through a read and a write-back in the cycle
// after, then blanks the bottom row. The result register lets the next
// transaction in while a result still waits.
module text_console_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // char_code[7:0], cell_index[18:8], zero
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // cell_value[15:0], cursor_row_out[20:16],
                                        // cursor_col_out[27:21], scrolled[28], zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data      // text_attribute[7:0]
);

    logic [7:0]                 r_attr;
    tcw_pkg::t_ram_req          ram_req;
    logic [tcw_pkg::CELL_W-1:0] ram_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::ATTR_RESET;
        end else if (i_cfg_valid) begin
            r_attr <= i_cfg_data;
        end
    end

    tcw_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_opcode     (s_axis_tuser),
        .i_char_code  (s_axis_tdata[7:0]),
        .i_cell_index (s_axis_tdata[18:8]),
        .i_attr       (r_attr),
        .o_ram_req    (ram_req),
        .i_ram_rdata  (ram_rdata),
        .o_valid      (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_data       (m_axis_tdata)
    );

    tcw_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer testbench
// Drives put, clear, read and unused-opcode transactions into the console and
// checks every result against a cycle-free model of the screen and cursor or,
// for a typed row, against its stated result. A short directed table covers
// blank cells, out-of-range reads, the unused opcode and field extremes. Random
// phases follow, each under its own attribute, with random gaps on both sides,
// one long result hold-off and one gap-free phase.
// ----------------------------------------------------------------------------
module testbench;
    import tcw_pkg::*;

    localparam logic [1:0] OP_IDLE          = 2'd3;
    localparam int         LONG_HOLD_CYCLES = 3000;
    localparam int         DRAIN_CYCLES     = 40;
    localparam int         CYCLE_LIMIT      = 15_000_000;
    localparam int         PHASES           = 6;
    localparam int         PHASE_ITEMS      = 215;
    localparam int         MAX_PRINTED      = 40;

    typedef struct packed {
        logic              scrolled;
        logic [6:0]        col;
        logic [4:0]        row;
        logic [CELL_W-1:0] cell_value;
    } t_console_out;

    typedef struct packed {
        logic [1:0]   op;
        logic [7:0]   ch;
        logic [10:0]  idx;
        logic         typed;
        t_console_out want;
    } t_probe;

    localparam int NUM_PROBES = 20;

    // typed rows: {scrolled, col, row, cell_value}
    localparam t_probe PROBES [NUM_PROBES] = '{
        '{OP_READ,  8'h00, 11'd0,    1'b1, {1'b0, 7'd0, 5'd0, 16'h0F00}},
        '{OP_READ,  8'hFF, 11'd1999, 1'b1, {1'b0, 7'd0, 5'd0, 16'h0F00}},
        '{OP_READ,  8'h00, 11'd2000, 1'b1, {1'b0, 7'd0, 5'd0, 16'h0000}},
        '{OP_READ,  8'h00, 11'h7FF,  1'b1, {1'b0, 7'd0, 5'd0, 16'h0000}},
        '{OP_IDLE,  8'hFF, 11'h7FF,  1'b1, {1'b0, 7'd0, 5'd0, 16'h0000}},
        '{OP_PUT,   8'h00, 11'h7FF,  1'b1, {1'b0, 7'd1, 5'd0, 16'h0000}},
        '{OP_PUT,   8'hFF, 11'd0,    1'b1, {1'b0, 7'd2, 5'd0, 16'h0000}},
        '{OP_PUT,   8'h0A, 11'd5,    1'b1, {1'b0, 7'd0, 5'd1, 16'h0000}},
        '{OP_READ,  8'h00, 11'd0,    1'b1, {1'b0, 7'd0, 5'd1, 16'h0F00}},
        '{OP_READ,  8'h00, 11'd1,    1'b1, {1'b0, 7'd0, 5'd1, 16'h0FFF}},
        '{OP_PUT,   8'h41, 11'd0,    1'b0, 29'd0},
        '{OP_READ,  8'h00, 11'd80,   1'b0, 29'd0},
        '{OP_PUT,   8'h0A, 11'd0,    1'b0, 29'd0},
        '{OP_PUT,   8'h0A, 11'd0,    1'b0, 29'd0},
        '{OP_CLEAR, 8'h55, 11'h2AA,  1'b1, {1'b0, 7'd0, 5'd0, 16'h0000}},
        '{OP_READ,  8'h00, 11'd1,    1'b1, {1'b0, 7'd0, 5'd0, 16'h0F00}},
        '{OP_READ,  8'h00, 11'd80,   1'b1, {1'b0, 7'd0, 5'd0, 16'h0F00}},
        '{OP_PUT,   8'h7F, 11'd0,    1'b0, 29'd0},
        '{OP_READ,  8'h00, 11'd0,    1'b0, 29'd0},
        '{OP_IDLE,  8'h0A, 11'd0,    1'b0, 29'd0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    // model of the screen store, cursor and attribute
    logic [CELL_W-1:0] screen [CELL_COUNT];
    int                cur_row;
    int                cur_col;
    logic [7:0]        text_attr;

    t_console_out result_q [$];
    int           mismatches  = 0;
    int           cycle_count = 0;
    bit           steady      = 1'b0;
    bit           long_hold_req = 1'b0;

    text_console_writer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("text_console_writer regression: fail");
            $finish;
        end
    end

    function automatic void blank_screen();
        for (int k = 0; k < CELL_COUNT; k++)
            screen[k] = {text_attr, 8'h00};
    endfunction

    // Apply one transaction to the model and return the result it yields.
    function automatic t_console_out console_step(logic [1:0] op, logic [7:0] ch,
                                                  logic [10:0] idx);
        t_console_out res;
        res = '0;
        case (op)
            OP_PUT: begin
                if (ch == NEWLINE_CODE) begin
                    cur_row++;
                    cur_col = 0;
                end else begin
                    screen[cur_row * COLUMNS + cur_col] = {text_attr, ch};
                    cur_col++;
                end
                if (cur_col >= COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
                // move every row up one and blank the bottom row
                if (cur_row >= ROWS) begin
                    cur_row = ROWS - 1;
                    for (int k = 0; k < (ROWS - 1) * COLUMNS; k++)
                        screen[k] = screen[k + COLUMNS];
                    for (int k = (ROWS - 1) * COLUMNS; k < CELL_COUNT; k++)
                        screen[k] = {text_attr, 8'h00};
                    res.scrolled = 1'b1;
                end
            end
            OP_CLEAR: begin
                blank_screen();
                cur_row = 0;
                cur_col = 0;
            end
            OP_READ: begin
                if (idx < CELL_COUNT)
                    res.cell_value = screen[idx];
            end
            default: ;
        endcase
        res.row = cur_row[4:0];
        res.col = cur_col[6:0];
        return res;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int idle_span();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(20, 80);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch at cycle %0d: %s got 0x%0h, expected 0x%0h",
                     cycle_count, what, got, want);
    endtask

    // Offer one transaction; called and returning at a falling edge.
    task automatic offer_item(input logic [1:0] op, input logic [7:0] ch,
                              input logic [10:0] idx, input logic typed,
                              input t_console_out want);
        t_console_out predicted;
        int gap;
        gap = (!steady && $urandom_range(0, 99) < 30) ? idle_span() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b0, idx, ch};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = console_step(op, ch, idx);
        result_q.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (result_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        text_attr = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                long_hold_req = 1'b0;
            end else if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 12)
                    stall = idle_span();
            end
        end
    end

    always @(posedge i_clk) begin
        t_console_out got;
        t_console_out want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = t_console_out'(m_axis_tdata[28:0]);
            if (result_q.size() == 0) begin
                report_mismatch("result with nothing expected", m_axis_tdata, 0);
            end else begin
                want = result_q.pop_front();
                if (got.cell_value !== want.cell_value)
                    report_mismatch("cell_value", got.cell_value, want.cell_value);
                if (got.row !== want.row)
                    report_mismatch("cursor_row_out", got.row, want.row);
                if (got.col !== want.col)
                    report_mismatch("cursor_col_out", got.col, want.col);
                if (got.scrolled !== want.scrolled)
                    report_mismatch("scrolled", got.scrolled, want.scrolled);
            end
        end
    end

    initial begin : stimulus
        int          newline_permille [PHASES] = '{80, 0, 40, 150, 10, 60};
        int          r;
        logic [1:0]  op;
        logic [7:0]  ch;
        logic [10:0] idx;
        logic [7:0]  attr;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_PUT;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;

        text_attr = ATTR_RESET;
        cur_row   = 0;
        cur_col   = 0;
        blank_screen();

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table under the reset attribute
        foreach (PROBES[n])
            offer_item(PROBES[n].op, PROBES[n].ch, PROBES[n].idx,
                       PROBES[n].typed, PROBES[n].want);
        s_axis_tvalid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            // change the attribute only once the block has gone quiet
            wait_drained();
            attr = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom_range(1, 254));
            write_attribute(attr);
            steady = (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == 40)
                    long_hold_req = 1'b1;
                r   = $urandom_range(0, 999);
                ch  = 8'($urandom_range(0, 255));
                idx = 11'($urandom_range(0, 2047));
                if (r < 3) begin
                    op = OP_CLEAR;
                end else if (r < 23) begin
                    op = OP_IDLE;
                end else if (r < 223) begin
                    op  = OP_READ;
                    idx = ($urandom_range(0, 19) == 0) ? 11'($urandom_range(CELL_COUNT, 2047))
                                                       : 11'($urandom_range(0, CELL_COUNT - 1));
                end else begin
                    op = OP_PUT;
                    if ($urandom_range(0, 999) < newline_permille[p])
                        ch = NEWLINE_CODE;
                end
                offer_item(op, ch, idx, 1'b0, '0);
            end
            s_axis_tvalid <= 1'b0;
            steady = 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && result_q.size() == 0)
            $display("text_console_writer regression: pass");
        else
            $display("text_console_writer regression: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_engine.sv
rtl/text_console_writer.sv
verif/testbench.sv
